@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/msor_pkg.sv @@
// Shared types, constants and helpers of the spiral order reader.
package msor_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int LC_W        = 6;
  localparam int TOTAL_W     = 7;
  localparam int DIV_CNT_W   = 3;
  localparam int REG_IDX_W   = 1;

  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [DIM_W-1:0] ROW_COUNT_RST = 4'd3;
  localparam logic [DIM_W-1:0] COL_COUNT_RST = 4'd4;

  // One matrix run handed from the load side to the spiral engine.
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } cmd_t;

  // Element store write port.
  typedef struct packed {
    logic                     en;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
  } store_wr_t;

  // Command queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [4:0] {
    SP_IDLE   = 5'b00001,
    SP_TOP    = 5'b00010,
    SP_RIGHT  = 5'b00100,
    SP_BOTTOM = 5'b01000,
    SP_LEFT   = 5'b10000
  } sp_state_t;

  // Zero counts as one, anything above the maximum counts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

@@ rtl/core/msor_front.sv @@
// Load side: configuration registers, load position tracking and store writes.
module msor_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [msor_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [msor_pkg::DIM_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [msor_pkg::DATA_W-1:0] in_element_value,
  input  logic                              hold,
  output msor_pkg::store_wr_t               st_wr,
  output logic                              cmd_push,
  output msor_pkg::cmd_t                    cmd
);
  import msor_pkg::*;

  logic [DIM_W-1:0]     row_count_r;
  logic [DIM_W-1:0]     col_count_r;
  logic [LC_W-1:0]      lc_r;
  logic [ROW_W-1:0]     pos_row_r;
  logic [COL_W-1:0]     pos_col_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LC_W-1:0]      div_dvd_r;

  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] lc_ext;
  logic [TOTAL_W-1:0] lc_inc;
  logic               load_last;
  logic               over;
  logic               accept;
  logic               div_busy;
  logic [DIM_W-1:0]   div_part;
  logic               div_ge;
  logic [COL_W-1:0]   div_rem;
  logic [DIM_W-1:0]   col_inc;

  always_comb begin
    rows      = clamp_dim(row_count_r, DIM_W'(MAX_ROWS));
    cols      = clamp_dim(col_count_r, DIM_W'(MAX_COLS));
    total     = TOTAL_W'(rows) * TOTAL_W'(cols);
    lc_ext    = TOTAL_W'(lc_r);
    lc_inc    = lc_ext + TOTAL_W'(1);
    load_last = (lc_inc >= total);
    over      = (lc_ext >= total);
    div_busy  = (div_cnt_r != '0);
    // A register write and a load word never share an edge.
    in_ready  = !div_busy && !hold && !cfg_wr_en;
    accept    = in_valid && in_ready;
    // One restoring division step: the quotient shifts into pos_row_r and
    // the remainder stays in pos_col_r.
    div_part  = {pos_col_r, div_dvd_r[LC_W-1]};
    div_ge    = (div_part >= cols);
    div_rem   = div_ge ? COL_W'(div_part - cols) : COL_W'(div_part);
    col_inc   = DIM_W'(pos_col_r) + DIM_W'(1);
  end

  // A load count beyond the current matrix lands on its last position.
  assign st_wr.en   = accept;
  assign st_wr.row  = over ? ROW_W'(rows - DIM_W'(1)) : pos_row_r;
  assign st_wr.col  = over ? COL_W'(cols - DIM_W'(1)) : pos_col_r;
  assign st_wr.data = in_element_value;
  assign cmd_push   = accept && load_last;
  assign cmd.rows   = rows;
  assign cmd.cols   = cols;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
      lc_r        <= '0;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      div_cnt_r   <= '0;
      div_dvd_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count_r <= cfg_data;
        REG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
      // The load position is recomputed against the new column count.
      div_cnt_r <= DIV_CNT_W'(LC_W);
      div_dvd_r <= lc_r;
      pos_row_r <= '0;
      pos_col_r <= '0;
    end else if (div_busy) begin
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      div_dvd_r <= {div_dvd_r[LC_W-2:0], 1'b0};
      pos_row_r <= {pos_row_r[ROW_W-2:0], div_ge};
      pos_col_r <= div_rem;
    end else if (accept) begin
      if (load_last) begin
        lc_r      <= '0;
        pos_row_r <= '0;
        pos_col_r <= '0;
      end else begin
        lc_r <= LC_W'(lc_inc);
        if (col_inc == cols) begin
          pos_col_r <= '0;
          pos_row_r <= pos_row_r + ROW_W'(1);
        end else begin
          pos_col_r <= COL_W'(col_inc);
        end
      end
    end
  end

endmodule

@@ rtl/core/msor_cmd_fifo.sv @@
// Two-entry queue of matrix runs between the load side and the spiral engine.
module msor_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msor_pkg::cmd_t    push_data,
  input  logic              pop,
  output msor_pkg::cmd_t    pop_data,
  output msor_pkg::q_stat_t stat
);
  import msor_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/core/msor_spiral.sv @@
// Spiral engine: element store, boundary walker, read stage and output register.
module msor_spiral (
  input  logic                               clk,
  input  logic                               rst_n,
  input  msor_pkg::store_wr_t                st_wr,
  input  logic                               cmd_valid,
  input  msor_pkg::cmd_t                     cmd,
  output logic                               cmd_pop,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [msor_pkg::DATA_W-1:0] out_value,
  output logic [msor_pkg::ROW_W-1:0]         out_row,
  output logic [msor_pkg::COL_W-1:0]         out_col,
  output logic                               out_run_last
);
  import msor_pkg::*;

  logic signed [DATA_W-1:0] mem [STORE_DEPTH];

  sp_state_t        state_r, state_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [ROW_W-1:0] bot_r, bot_nxt;
  logic [COL_W-1:0] left_r, left_nxt;
  logic [COL_W-1:0] right_r, right_nxt;
  logic [LC_W-1:0]  cnt_r, cnt_nxt;
  logic [LC_W-1:0]  last_idx_r, last_idx_nxt;

  logic                     rd_v_r;
  logic [ROW_W-1:0]         rd_row_r;
  logic [COL_W-1:0]         rd_col_r;
  logic                     rd_last_r;
  logic signed [DATA_W-1:0] mem_q_r;
  logic                     out_v_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic                     out_last_r;

  logic               rd_adv;
  logic               issue;
  logic               last_now;
  logic [TOTAL_W-1:0] cmd_total;
  logic [ROW_W-1:0]   top_p1;
  logic [COL_W-1:0]   left_p1;

  assign cmd_pop  = (state_r == SP_IDLE) && cmd_valid;
  assign rd_adv   = rd_v_r && (!out_v_r || out_ready);
  assign issue    = (state_r != SP_IDLE) && (!rd_v_r || rd_adv);
  assign last_now = (cnt_r == last_idx_r);
  assign busy     = (state_r != SP_IDLE) || rd_v_r || out_v_r;

  always_comb begin
    cmd_total    = TOTAL_W'(cmd.rows) * TOTAL_W'(cmd.cols);
    top_p1       = top_r + ROW_W'(1);
    left_p1      = left_r + COL_W'(1);
    state_nxt    = state_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    cnt_nxt      = cnt_r;
    last_idx_nxt = last_idx_r;
    if (cmd_pop) begin
      state_nxt    = SP_TOP;
      cur_row_nxt  = '0;
      cur_col_nxt  = '0;
      top_nxt      = '0;
      left_nxt     = '0;
      bot_nxt      = ROW_W'(cmd.rows - DIM_W'(1));
      right_nxt    = COL_W'(cmd.cols - DIM_W'(1));
      cnt_nxt      = '0;
      last_idx_nxt = LC_W'(cmd_total - TOTAL_W'(1));
    end else if (issue) begin
      cnt_nxt = cnt_r + LC_W'(1);
      if (last_now) begin
        state_nxt = SP_IDLE;
      end else begin
        unique case (state_r)
          SP_TOP: begin
            if (cur_col_r != right_r) begin
              cur_col_nxt = cur_col_r + COL_W'(1);
            end else begin
              state_nxt   = SP_RIGHT;
              cur_row_nxt = cur_row_r + ROW_W'(1);
            end
          end
          SP_RIGHT: begin
            if (cur_row_r != bot_r) begin
              cur_row_nxt = cur_row_r + ROW_W'(1);
            end else begin
              state_nxt   = SP_BOTTOM;
              cur_col_nxt = cur_col_r - COL_W'(1);
            end
          end
          SP_BOTTOM: begin
            if (cur_col_r != left_r) begin
              cur_col_nxt = cur_col_r - COL_W'(1);
            end else begin
              state_nxt   = SP_LEFT;
              cur_row_nxt = cur_row_r - ROW_W'(1);
            end
          end
          SP_LEFT: begin
            if (cur_row_r != top_p1) begin
              cur_row_nxt = cur_row_r - ROW_W'(1);
            end else begin
              // Ring finished: every bound closes in by one.
              state_nxt   = SP_TOP;
              top_nxt     = top_p1;
              bot_nxt     = bot_r - ROW_W'(1);
              left_nxt    = left_p1;
              right_nxt   = right_r - COL_W'(1);
              cur_row_nxt = top_p1;
              cur_col_nxt = left_p1;
            end
          end
          default: state_nxt = SP_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue || (rd_v_r && !rd_adv);
      if (rd_adv) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    cnt_r      <= cnt_nxt;
    last_idx_r <= last_idx_nxt;
    if (issue) begin
      rd_row_r  <= cur_row_r;
      rd_col_r  <= cur_col_r;
      rd_last_r <= last_now;
    end
    if (rd_adv) begin
      out_value_r <= mem_q_r;
      out_row_r   <= rd_row_r;
      out_col_r   <= rd_col_r;
      out_last_r  <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) mem[{st_wr.row, st_wr.col}] <= st_wr.data;
  end

  always_ff @(posedge clk) begin
    if (issue) mem_q_r <= mem[{cur_row_r, cur_col_r}];
  end

  assign out_valid    = out_v_r;
  assign out_value    = out_value_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_run_last = out_last_r;

endmodule

@@ rtl/core/matrix_spiral_order_reader_core.sv @@
// Top level of the matrix spiral order reader.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_ready   | in_element_value
//   out      | out_valid / out_ready | out_value, out_row, out_col, out_run_last
//   cfg      | cfg_wr_en             | cfg_index, cfg_data
//
// A load word is taken when in_valid and in_ready are both high; the word that completes
// the matrix starts a run, and loading holds off until the whole run is delivered.
// The first word of a run is offered after the queue pop, the store read register and
// the output register, then one word per cycle while out_ready stays high.
// A register write holds the load side in its own cycle and while a one-bit-per-cycle
// divider recomputes the load position; reset leaves the store as is.
module matrix_spiral_order_reader_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [msor_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [msor_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [msor_pkg::DATA_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [msor_pkg::DATA_W-1:0] out_value,
  output logic [msor_pkg::ROW_W-1:0]         out_row,
  output logic [msor_pkg::COL_W-1:0]         out_col,
  output logic                               out_run_last
);
  import msor_pkg::*;

  store_wr_t st_wr;
  logic      cmd_push;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  logic      cmd_pop;
  q_stat_t   q_stat;
  logic      back_busy;
  logic      hold;

  // The store is shared, so a new matrix waits until the previous run is out.
  assign hold = !q_stat.empty || back_busy;

  msor_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .hold             (hold),
    .st_wr            (st_wr),
    .cmd_push         (cmd_push),
    .cmd              (push_cmd)
  );

  msor_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_cmd),
    .pop       (cmd_pop),
    .pop_data  (pop_cmd),
    .stat      (q_stat)
  );

  msor_spiral u_spiral (
    .clk          (clk),
    .rst_n        (rst_n),
    .st_wr        (st_wr),
    .cmd_valid    (!q_stat.empty),
    .cmd          (pop_cmd),
    .cmd_pop      (cmd_pop),
    .busy         (back_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_last (out_run_last)
  );

endmodule

@@ rtl/core/msor_checker.sv @@
// Port-level checks of the spiral order reader, bound to the top level.
`include "assert_macros.svh"

module msor_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_wr_en,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [msor_pkg::DATA_W-1:0] out_value,
  input logic                               out_run_last
);

  // A stalled output word keeps its value.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value), "output word changed while stalled")

  // Loading is held off while any word of a run waits to be taken.
  `ASSERT_CLK(a_no_load_during_run, out_valid |-> !in_ready, "load accepted during a run")

  // Nothing follows the last word of a run until a new matrix arrives.
  `ASSERT_CLK(a_run_ends, out_valid && out_ready && out_run_last |=> !out_valid, "word after end of run")

  // A register write stalls loading while the load position is recomputed.
  `ASSERT_CLK(a_cfg_stall, cfg_wr_en |=> !in_ready, "load accepted right after a register write")

  // Coming out of reset no word is offered.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind matrix_spiral_order_reader_core msor_checker u_msor_checker (.*);

@@ tb/matrix_spiral_order_reader_core_tb.sv @@
// Self-checking testbench for the matrix spiral order reader core.
`timescale 1ns / 1ps

module matrix_spiral_order_reader_core_tb;
  import msor_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 280;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } spiral_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = '0;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic                     out_run_last;

  // Shadow copy of the block's store, load position and size registers.
  logic signed [DATA_W-1:0] element_mem [STORE_DEPTH];
  logic [DIM_W-1:0]         rows_reg = ROW_COUNT_RST;
  logic [DIM_W-1:0]         cols_reg = COL_COUNT_RST;
  int                       load_pos = 0;
  int                       run_total;
  int                       emitted;
  spiral_word_t             spiral_expected [$];

  int  errors = 0;
  int  words_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;

  matrix_spiral_order_reader_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_run_last     (out_run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit take_gap();
    return !quiet && ($urandom_range(0, 99) < 17);
  endfunction

  function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int max_dim);
    if (raw == '0) return 1;
    if (int'(raw) > max_dim) return max_dim;
    return int'(raw);
  endfunction

  function automatic int matrix_total();
    return eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS);
  endfunction

  function automatic void push_word(input int r, input int c);
    spiral_word_t w;
    emitted++;
    w.value = element_mem[r * MAX_COLS + c];
    w.row   = r[ROW_W-1:0];
    w.col   = c[COL_W-1:0];
    w.last  = (emitted == run_total);
    spiral_expected.push_back(w);
  endfunction

  // Stores one element and, when it completes the matrix, queues the whole spiral.
  function automatic void predict_load(input logic signed [DATA_W-1:0] v);
    int rows, cols, total, pos, top, bot, lft, rgt, i;
    rows  = eff_dim(rows_reg, MAX_ROWS);
    cols  = eff_dim(cols_reg, MAX_COLS);
    total = rows * cols;
    // A shrunken matrix takes the late word at its last position.
    pos = (load_pos >= total) ? total - 1 : load_pos;
    element_mem[(pos / cols) * MAX_COLS + pos % cols] = v;
    if (pos + 1 < total) begin
      load_pos = pos + 1;
      return;
    end
    load_pos  = 0;
    run_total = total;
    emitted   = 0;
    top = 0;
    bot = rows - 1;
    lft = 0;
    rgt = cols - 1;
    while (top <= bot && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) push_word(top, i);
      top++;
      for (i = top; i <= bot; i++) push_word(i, rgt);
      rgt--;
      if (top <= bot) begin
        for (i = rgt; i >= lft; i--) push_word(bot, i);
        bot--;
      end
      if (lft <= rgt) begin
        for (i = bot; i >= top; i--) push_word(i, lft);
        lft++;
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] random_element();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_element(input logic signed [DATA_W-1:0] v);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_load(v);
    words_sent++;
    @(negedge clk);
  endtask

  // Drains all expected words, then lets the load side settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (spiral_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One write cycle, then the port stays quiet before the next caller drives it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = d;
    else cols_reg = d;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    wait_idle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
  endtask

  function automatic logic [DIM_W-1:0] random_dim();
    if ($urandom_range(0, 7) == 0) return DIM_W'($urandom_range(0, 15));
    return DIM_W'($urandom_range(1, 8));
  endfunction

  // Changes one or both size registers at random.
  task automatic pick_size();
    int sel;
    sel = $urandom_range(0, 2);
    wait_idle();
    if (sel != 1) write_reg(REG_ROW_COUNT, random_dim());
    if (sel != 0) write_reg(REG_COL_COUNT, random_dim());
  endtask

  task automatic finish_matrix();
    do send_element(random_element()); while (load_pos != 0);
  endtask

  task automatic test_reset_size();
    int i;
    send_element({1'b1, {(DATA_W-1){1'b0}}});
    send_element({1'b0, {(DATA_W-1){1'b1}}});
    send_element('0);
    send_element('1);
    for (i = 4; i < 12; i++) send_element($urandom);
    wait_idle();
  endtask

  task automatic test_zero_size();
    set_size('0, '0);
    send_element({1'b0, {(DATA_W-1){1'b1}}});
    wait_idle();
  endtask

  task automatic test_tall_column();
    set_size(4'd15, '0);
    finish_matrix();
    wait_idle();
  endtask

  // Three words into a 2x2 matrix, then shrink to 1x2: the next word closes it.
  task automatic test_resize_mid_load();
    set_size(4'd2, 4'd2);
    repeat (3) send_element(random_element());
    set_size(4'd1, 4'd2);
    finish_matrix();
    wait_idle();
  endtask

  task automatic test_random();
    int stop_at, total;
    // A full 8x8 matrix first, so that every entry has been written before
    // any resize in the middle of a load.
    set_size(4'd8, 4'd8);
    finish_matrix();
    stop_at = words_sent + RANDOM_ITEMS;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 99) < 70) pick_size();
        finish_matrix();
      end else begin
        total = matrix_total();
        if (total > 1) repeat ($urandom_range(1, total - 1)) send_element(random_element());
        pick_size();
        finish_matrix();
      end
    end
    wait_idle();
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    repeat (4) begin
      pick_size();
      finish_matrix();
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  // The receiver stops for a long while; the block fills up and stalls loading.
  task automatic test_output_hold();
    set_size(4'd4, 4'd4);
    hold_request = 1'b1;
    repeat (3) finish_matrix();
    wait_idle();
  endtask

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  initial begin : scoreboard
    spiral_word_t w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (spiral_expected.size() == 0) begin
          $error("unexpected word: value %0d row %0d col %0d", out_value, out_row, out_col);
          errors++;
        end else begin
          w = spiral_expected.pop_front();
          if (out_value !== w.value) begin
            $error("out_value: expected %0d, got %0d", w.value, out_value);
            errors++;
          end
          if (out_row !== w.row) begin
            $error("out_row: expected %0d, got %0d", w.row, out_row);
            errors++;
          end
          if (out_col !== w.col) begin
            $error("out_col: expected %0d, got %0d", w.col, out_col);
            errors++;
          end
          if (out_run_last !== w.last) begin
            $error("out_run_last: expected %0d, got %0d", w.last, out_run_last);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) still = 0;
      else still++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_size();
    test_zero_size();
    test_tall_column();
    test_resize_mid_load();
    test_random();
    test_streaming();
    test_output_hold();
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && spiral_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/msor_pkg.sv
rtl/core/msor_front.sv
rtl/core/msor_cmd_fifo.sv
rtl/core/msor_spiral.sv
rtl/core/matrix_spiral_order_reader_core.sv
rtl/core/msor_checker.sv
tb/matrix_spiral_order_reader_core_tb.sv
